/* design/cdq_pkg.sv */
`timescale 1ns / 1ps

package cdq_pkg;

    // Word and field widths
    localparam int WORD_W  = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 4;
    localparam int S_DATA_W = 32;  // value
    localparam int M_DATA_W = 40;  // data, status, occupancy, zero pad

    // Default number of cells
    localparam int CDQ_DEPTH = 8;

    // Operation codes carried in tuser
    localparam logic [KIND_W-1:0] KIND_INS_FRONT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INS_REAR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEL_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DEL_REAR   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_REAR  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // Command broadcast to every cell of the chain, at most one bit set
    typedef struct packed {
        logic shift_r;    // push at front: every word moves one cell back
        logic shift_l;    // pop at front: every word moves one cell forward
        logic put_rear;   // first free cell takes the new word
        logic drop_rear;  // last occupied cell empties
    } t_cell_op;

endpackage

/* design/cdq_cell.sv */
`timescale 1ns / 1ps

module cdq_cell
    import cdq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_op          i_op,
    input  logic [WORD_W-1:0] i_new_word,
    input  logic [WORD_W-1:0] i_left_word,
    input  logic              i_left_valid,
    input  logic [WORD_W-1:0] i_right_word,
    input  logic              i_right_valid,
    output logic [WORD_W-1:0] o_word,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_rear_tap
);

    logic [WORD_W-1:0] r_word;
    logic              r_valid;
    logic [WORD_W-1:0] n_word;
    logic              n_valid;
    logic              w_is_rear;
    logic              w_is_slot;

    // This cell holds the rear word, or is the first free one
    assign w_is_rear = r_valid && !i_right_valid;
    assign w_is_slot = !r_valid && i_left_valid;

    // Next contents from the broadcast command and the neighbors
    always_comb begin
        n_word  = r_word;
        n_valid = r_valid;
        if (i_op.shift_r) begin
            n_word  = i_left_word;
            n_valid = i_left_valid;
        end else if (i_op.shift_l) begin
            n_word  = i_right_word;
            n_valid = i_right_valid;
        end else if (i_op.put_rear && w_is_slot) begin
            n_word  = i_new_word;
            n_valid = 1'b1;
        end else if (i_op.drop_rear && w_is_rear) begin
            n_valid = 1'b0;
        end
    end

    // Occupancy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Word, no reset; only read while its flag is set
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word     = r_word;
    assign o_valid    = r_valid;
    assign o_rear_tap = w_is_rear ? r_word : '0;

endmodule

/* design/circular_deque_core.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Fields (lowest bit first)
// s_axis   | in  | tdata: value[31:0]; tuser: kind[2:0]
// m_axis   | out | tdata: data[31:0], status[33:32], occupancy[37:34], zero pad
//
// The deque is a row of DEPTH cells with the front word always in cell 0.
// Each beat is handled in the cycle it is accepted; its result is registered
// and shows in the next cycle, so a beat can be taken every cycle while the
// result register drains. Cells shift together, one cell per cycle, on an accepted front insert or delete.
// Reset (synchronous, active low) empties all cells and the result register.
// A stalled result register holds its beat and stops input until taken.

module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = CDQ_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // value[31:0]
    input  logic [KIND_W-1:0]   i_s_tuser,   // kind[2:0]
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata    // data, status, occupancy, pad
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PAD_W = M_DATA_W - WORD_W - STAT_W - OCC_W;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    t_cell_op          w_op;
    logic [WORD_W-1:0] w_res_data;
    logic [STAT_W-1:0] w_res_stat;
    logic [WORD_W-1:0] w_rear_word;

    logic [WORD_W-1:0] w_word [DEPTH];
    logic              w_valid [DEPTH];
    logic [WORD_W-1:0] w_tap  [DEPTH];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    // Chain of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] w_lw;
        logic              w_lv;
        logic [WORD_W-1:0] w_rw;
        logic              w_rv;

        if (g == 0) begin : g_first
            assign w_lw = i_s_tdata;
            assign w_lv = 1'b1;
        end else begin : g_mid_l
            assign w_lw = w_word[g-1];
            assign w_lv = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rw = '0;
            assign w_rv = 1'b0;
        end else begin : g_mid_r
            assign w_rw = w_word[g+1];
            assign w_rv = w_valid[g+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (w_op),
            .i_new_word   (i_s_tdata),
            .i_left_word  (w_lw),
            .i_left_valid (w_lv),
            .i_right_word (w_rw),
            .i_right_valid(w_rv),
            .o_word       (w_word[g]),
            .o_valid      (w_valid[g]),
            .o_rear_tap   (w_tap[g])
        );
    end

    // Rear word: only the last occupied cell drives its tap
    always_comb begin
        w_rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear_word = w_rear_word | w_tap[i];
        end
    end

    // Decode the operation
    always_comb begin
        w_op       = '0;
        n_count    = r_count;
        w_res_data = '0;
        w_res_stat = STAT_OK;
        case (i_s_tuser)
            KIND_INS_FRONT, KIND_INS_REAR: begin
                if (w_full) begin
                    w_res_stat = STAT_FULL;
                end else begin
                    w_op.shift_r  = (i_s_tuser == KIND_INS_FRONT);
                    w_op.put_rear = (i_s_tuser == KIND_INS_REAR);
                    n_count       = r_count + 1'b1;
                end
            end
            KIND_DEL_FRONT, KIND_PEEK_FRONT: begin
                if (w_empty) begin
                    w_res_stat = STAT_EMPTY;
                end else begin
                    w_res_data  = w_word[0];
                    w_op.shift_l = (i_s_tuser == KIND_DEL_FRONT);
                    if (i_s_tuser == KIND_DEL_FRONT) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            KIND_DEL_REAR, KIND_PEEK_REAR: begin
                if (w_empty) begin
                    w_res_stat = STAT_EMPTY;
                end else begin
                    w_res_data     = w_rear_word;
                    w_op.drop_rear = (i_s_tuser == KIND_DEL_REAR);
                    if (i_s_tuser == KIND_DEL_REAR) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                // unused kinds leave everything as is
            end
        endcase
        if (!w_accept) begin
            w_op    = '0;
            n_count = r_count;
        end
    end

    // Occupancy counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {PAD_W'(0), OCC_W'(n_count), w_res_stat, w_res_data};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // Checks
    logic [CNT_W-1:0] w_valid_cnt;
    always_comb begin
        w_valid_cnt = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_valid_cnt = w_valid_cnt + CNT_W'(w_valid[i]);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_cells_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid_cnt == r_count)
        else $error("occupied cells disagree with count");

    a_front_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_valid[0] == !w_empty)
        else $error("front cell flag disagrees with count");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !w_full
            && (i_s_tuser == KIND_INS_FRONT || i_s_tuser == KIND_INS_REAR)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow the deque");

endmodule

/* tb/circular_deque_core_test.sv */
`timescale 1ns / 1ps

module circular_deque_core_test;
    import cdq_pkg::*;

    localparam int DEPTH       = CDQ_DEPTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 60;      // receiver hold-off, in cycles
    localparam int DRAIN_WAIT  = 10;      // result register latency plus margin

    // Kinds the block treats as no-ops
    localparam logic [KIND_W-1:0] KIND_NOP_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_NOP_B = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] value;
    } t_deque_op;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [STAT_W-1:0] status;
        logic [OCC_W-1:0]  occ;
    } t_deque_result;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]   s_tuser  = '0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;

    circular_deque_core #(.DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // value[31:0]
        .i_s_tuser  (s_tuser),    // kind[2:0]
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)     // data[31:0], status[33:32], occupancy[37:34], pad
    );

    always #4 i_clk = ~i_clk;

    // Ops waiting to be sent, results waiting to be seen
    t_deque_op     op_queue[$];
    t_deque_result pending_results[$];

    // Shadow deque state
    logic [WORD_W-1:0] cells [DEPTH];
    int                front = 0;
    int                fill  = 0;

    // Traffic shaping, set per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    // Apply one op to the shadow deque and return its result
    function automatic t_deque_result deque_apply(t_deque_op op);
        t_deque_result r;
        int            pos;
        r = '{data: '0, status: STAT_OK, occ: '0};
        case (op.kind)
            KIND_INS_FRONT, KIND_INS_REAR: begin
                if (fill >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (op.kind == KIND_INS_FRONT) begin
                    front = (front + DEPTH - 1) % DEPTH;
                    cells[front] = op.value;
                    fill++;
                end else begin
                    cells[(front + fill) % DEPTH] = op.value;
                    fill++;
                end
            end
            KIND_DEL_FRONT, KIND_PEEK_FRONT: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.data = cells[front];
                    if (op.kind == KIND_DEL_FRONT) begin
                        front = (front + 1) % DEPTH;
                        fill--;
                    end
                end
            end
            KIND_DEL_REAR, KIND_PEEK_REAR: begin
                if (fill == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    pos = (front + fill - 1) % DEPTH;
                    r.data = cells[pos];
                    if (op.kind == KIND_DEL_REAR)
                        fill--;
                end
            end
            default: ;
        endcase
        r.occ = OCC_W'(fill);
        return r;
    endfunction

    function automatic void push_op(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] value);
        t_deque_op op;
        op.kind  = kind;
        op.value = value;
        op_queue.push_back(op);
    endfunction

    // Random ops in bursts that lean toward filling, draining or neither, so the
    // occupancy sweeps between empty and full; a few no-op kinds mixed in
    task automatic queue_ops(int n);
        int left;
        int burst;
        int ins_pct;
        int r;
        logic [KIND_W-1:0] k;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(20, 4);
            case ($urandom_range(2))
                0: ins_pct = 75;
                1: ins_pct = 20;
                default: ins_pct = 45;
            endcase
            for (int i = 0; i < burst && left > 0; i++) begin
                r = $urandom_range(99);
                if (r < 4)
                    k = $urandom_range(1) ? KIND_NOP_A : KIND_NOP_B;
                else if (r < 4 + ins_pct)
                    k = $urandom_range(1) ? KIND_INS_FRONT : KIND_INS_REAR;
                else
                    case ($urandom_range(9))
                        0, 1, 2: k = KIND_DEL_FRONT;
                        3, 4, 5: k = KIND_DEL_REAR;
                        6, 7:    k = KIND_PEEK_FRONT;
                        default: k = KIND_PEEK_REAR;
                    endcase
                push_op(k, $urandom);
                left--;
            end
        end
    endtask

    // Wait until every queued op has been sent and its result has come back
    task automatic wait_drained();
        while (op_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender: offer the head of op_queue, predict on each accepted beat
    always @(posedge i_clk) begin : sender_p
        t_deque_op op;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                op = op_queue.pop_front();
                pending_results.push_back(deque_apply(op));
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat until taken
            end else if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= op_queue[0].value;
                s_tuser  <= op_queue[0].kind;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each accepted beat, then pick next tready
    always @(posedge i_clk) begin : receiver_p
        t_deque_result got;
        t_deque_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.data   = m_tdata[WORD_W-1:0];
            got.status = m_tdata[WORD_W +: STAT_W];
            got.occ    = m_tdata[WORD_W+STAT_W +: OCC_W];
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected: %h", $time, m_tdata);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.data !== want.data) begin
                    $display("%0t: data mismatch: expected %h, got %h",
                             $time, want.data, got.data);
                    err_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, got.status);
                    err_count++;
                end
                if (got.occ !== want.occ) begin
                    $display("%0t: occupancy mismatch: expected %0d, got %0d",
                             $time, want.occ, got.occ);
                    err_count++;
                end
                if (m_tdata[M_DATA_W-1:WORD_W+STAT_W+OCC_W] !== '0) begin
                    $display("%0t: pad bits mismatch: expected 0, got %b", $time,
                             m_tdata[M_DATA_W-1:WORD_W+STAT_W+OCC_W]);
                    err_count++;
                end
            end
        end
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: errors on empty, no-op kinds, extreme words, fill past
        // full with front wrap, then a few deletes
        push_op(KIND_PEEK_FRONT, 32'h0);
        push_op(KIND_PEEK_REAR,  32'hFFFF_FFFF);
        push_op(KIND_DEL_FRONT,  32'h0);
        push_op(KIND_DEL_REAR,   32'h0);
        push_op(KIND_NOP_A,      32'h1234_5678);
        push_op(KIND_NOP_B,      32'hFFFF_FFFF);
        push_op(KIND_INS_FRONT,  32'h7FFF_FFFF);
        push_op(KIND_INS_REAR,   32'h8000_0000);
        push_op(KIND_PEEK_FRONT, 32'h0);
        push_op(KIND_PEEK_REAR,  32'h0);
        push_op(KIND_INS_FRONT,  32'hFFFF_FFFF);
        push_op(KIND_INS_REAR,   32'h0000_0000);
        push_op(KIND_INS_FRONT,  32'h5555_5555);
        push_op(KIND_INS_REAR,   32'hAAAA_AAAA);
        push_op(KIND_INS_FRONT,  32'h0000_0001);
        push_op(KIND_INS_REAR,   32'hFFFF_FFFE);
        push_op(KIND_INS_REAR,   32'hDEAD_BEEF);
        push_op(KIND_INS_FRONT,  32'hCAFE_F00D);
        push_op(KIND_NOP_A,      32'h0);
        push_op(KIND_PEEK_REAR,  32'h0);
        push_op(KIND_DEL_FRONT,  32'h0);
        push_op(KIND_DEL_REAR,   32'h0);
        push_op(KIND_INS_FRONT,  32'h8000_0001);
        push_op(KIND_PEEK_FRONT, 32'h0);
        wait_drained();

        // Random phases: free flow, sender idle, receiver stall, both
        send_idle_pct = 0;  recv_stall_pct = 0;  queue_ops(110); wait_drained();
        send_idle_pct = 76; recv_stall_pct = 0;  queue_ops(110); wait_drained();
        send_idle_pct = 0;  recv_stall_pct = 76; queue_ops(110); wait_drained();
        send_idle_pct = 34; recv_stall_pct = 34; queue_ops(110); wait_drained();

        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;  recv_stall_pct = 0;
        queue_ops(50);
        hold_requests = hold_requests + 1;
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
design/cdq_pkg.sv
design/cdq_cell.sv
design/circular_deque_core.sv
tb/circular_deque_core_test.sv
